>>> design/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps

package sha_pkg;

   localparam int BLOCK_BITS = 512;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS = 64;
   localparam int DIGEST_BITS = 256;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;

   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [60:0] TOTAL_MAX = '1;
   localparam logic [1:0] LAST_IDX = 2'd3;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // One 64-byte block handed from the front end to the compression engine.
   typedef struct packed {
      logic                  last_blk;
      logic [BLOCK_BITS-1:0] block;
   } job_type;

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

>>> design/sha_front.sv
// Front end: takes message bytes, appends the padding and length, and emits full blocks.
`timescale 1ns / 1ps

module sha_front import sha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [0:0] req_tuser,   // [0] byte_valid
   input  logic       req_tlast,   // end_of_message
   input  logic       q_full,
   output logic       push_valid,
   output job_type    push_job
);

   typedef enum logic [3:0] {
      F_COLLECT = 4'b0001,
      F_MARK    = 4'b0010,
      F_ZERO    = 4'b0100,
      F_LEN     = 4'b1000
   } fstate_type;

   fstate_type            state_ff, state_in;
   logic [5:0]            fill_ff, fill_in;
   logic [60:0]           total_ff, total_in;
   logic [63:0]           len_ff, len_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic                  step;
   logic [7:0]            sbyte;
   logic                  accept;
   logic [60:0]           total_after;

   assign req_tready = (state_ff == F_COLLECT) && !q_full;
   assign accept = req_tvalid && req_tready;
   assign total_after = (req_tuser[0] && (total_ff != TOTAL_MAX)) ?
                        61'(total_ff + 61'd1) : total_ff;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      total_in = total_ff;
      len_in = len_ff;
      blk_in = blk_ff;
      step = 1'b0;
      sbyte = 8'h00;
      unique case (state_ff)
         F_COLLECT: begin
            if (accept) begin
               step = req_tuser[0];
               sbyte = req_tdata;
               if (req_tlast) begin
                  len_in = {total_after, 3'b000};
                  total_in = '0;
                  state_in = F_MARK;
               end else begin
                  total_in = total_after;
               end
            end
         end
         F_MARK: begin
            step = !q_full;
            sbyte = PAD_MARK;
            if (!q_full) begin
               state_in = (fill_ff == 6'(LEN_POS - 6'd1)) ? F_LEN : F_ZERO;
            end
         end
         F_ZERO: begin
            step = !q_full;
            if (!q_full && (fill_ff == 6'(LEN_POS - 6'd1))) begin
               state_in = F_LEN;
            end
         end
         F_LEN: begin
            step = !q_full;
            sbyte = len_ff[63:56];
            if (!q_full) begin
               len_in = {len_ff[55:0], 8'h00};
               if (fill_ff == LAST_FILL) begin
                  state_in = F_COLLECT;
               end
            end
         end
         default: state_in = F_COLLECT;
      endcase
      if (step) begin
         blk_in = {blk_ff[BLOCK_BITS-9:0], sbyte};
         fill_in = 6'(fill_ff + 6'd1);
      end
   end

   // A block leaves on the step that writes its 64th byte; the one finished
   // while the length goes in closes the message.
   assign push_valid = step && (fill_ff == LAST_FILL);
   assign push_job.last_blk = (state_ff == F_LEN);
   assign push_job.block = {blk_ff[BLOCK_BITS-9:0], sbyte};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_COLLECT;
         fill_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
      end
      len_ff <= len_in;
      blk_ff <= blk_in;
   end

endmodule

>>> design/sha_queue.sv
// Two-entry block queue between the front end and the compression engine.
`timescale 1ns / 1ps

module sha_queue import sha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    q_full,
   input  logic    pop,
   output logic    q_valid,
   output job_type q_head
);

   job_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     cnt_ff;

   assign q_full = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_head = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= QPTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= QPTR_W'(rd_ptr_ff + 1'b1);
         end
         if (push_valid && !pop) begin
            cnt_ff <= (QPTR_W+1)'(cnt_ff + 1'b1);
         end else if (pop && !push_valid) begin
            cnt_ff <= (QPTR_W+1)'(cnt_ff - 1'b1);
         end
      end
      if (push_valid) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> design/sha_back.sv
// Back end: one compression round per cycle, hash update and digest output register.
`timescale 1ns / 1ps

module sha_back import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  job_type     q_head,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [2:0] {
      B_IDLE   = 3'b001,
      B_ROUND  = 3'b010,
      B_UPDATE = 3'b100
   } bstate_type;

   bstate_type             state_ff, state_in;
   logic [31:0]            hs_ff [8];
   logic [31:0]            hs_in [8];
   logic [31:0]            v_ff [8];
   logic [31:0]            v_in [8];
   logic [31:0]            w_ff [BLOCK_WORDS];
   logic [31:0]            w_in [BLOCK_WORDS];
   logic [5:0]             round_ff, round_in;
   logic                   last_ff, last_in;
   logic [DIGEST_BITS-1:0] dig_ff, dig_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   busy_ff, busy_in;
   logic [31:0]            t1, t2, w_new;
   logic [31:0]            sums [8];

   assign t1 = v_ff[7] + big_sig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[round_ff] + w_ff[0];
   assign t2 = big_sig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_new = w_ff[0] + small_sig0(w_ff[1]) + w_ff[9] + small_sig1(w_ff[14]);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sums[i] = hs_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      hs_in = hs_ff;
      v_in = v_ff;
      w_in = w_ff;
      round_in = round_ff;
      last_in = last_ff;
      dig_in = dig_ff;
      idx_in = idx_ff;
      busy_in = busy_ff;
      pop = 1'b0;
      if (busy_ff && rsp_tready) begin
         dig_in = {dig_ff[DIGEST_BITS-65:0], 64'h0};
         idx_in = 2'(idx_ff + 2'd1);
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               for (int i = 0; i < BLOCK_WORDS; i++) begin
                  w_in[i] = q_head.block[BLOCK_BITS-1-32*i -: 32];
               end
               v_in = hs_ff;
               round_in = '0;
               last_in = q_head.last_blk;
               state_in = B_ROUND;
            end
         end
         B_ROUND: begin
            for (int i = 0; i < BLOCK_WORDS-1; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[BLOCK_WORDS-1] = w_new;
            for (int i = 7; i > 0; i--) begin
               v_in[i] = v_ff[i-1];
            end
            v_in[4] = v_ff[3] + t1;
            v_in[0] = t1 + t2;
            round_in = 6'(round_ff + 6'd1);
            if (round_ff == LAST_ROUND) begin
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            if (!last_ff) begin
               hs_in = sums;
               state_in = B_IDLE;
            end else if (!busy_ff) begin
               for (int i = 0; i < 8; i++) begin
                  dig_in[DIGEST_BITS-1-32*i -: 32] = sums[i];
               end
               hs_in = INIT_H;
               idx_in = '0;
               busy_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata = dig_ff[DIGEST_BITS-1 -: 64];
   assign rsp_tuser = idx_ff;
   assign rsp_tlast = (idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         hs_ff <= INIT_H;
         round_ff <= '0;
         last_ff <= 1'b0;
         idx_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hs_ff <= hs_in;
         round_ff <= round_in;
         last_ff <= last_in;
         idx_ff <= idx_in;
         busy_ff <= busy_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
      dig_ff <= dig_in;
   end

endmodule

>>> design/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte-stream hasher: front end, block queue and compression engine.
// Message bytes are taken at one request per cycle while the front end is collecting and the block queue has room.
// In the compression engine each 64-byte block goes through load, 64 rounds and the hash update.
// At the end of a message the front end shifts in padding and length at one byte per cycle
// while the queue has room; the digest then leaves as four 64-bit words, one per accepted cycle.
// Reset is synchronous and active high: it empties the queue and restores the initial hash.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);

   // Blocks travel from the front end to the engine through a two-entry
   // queue, so the front end can fill the next block while the engine works.
   logic    push_valid;
   job_type push_job;
   logic    q_full;
   logic    q_valid;
   job_type q_head;
   logic    pop;

   // The front end packs bytes, counts the message length and, after the
   // end of a message, feeds the 0x80 marker, zeros and the bit length
   // through the same byte path, so every block it emits is complete.
   sha_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   sha_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_head     (q_head)
   );

   // The engine runs one round per cycle and keeps the running hash. The
   // digest of a finished message sits in its own output register, so the
   // engine can go on with the next message while the words drain.
   sha_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The front end never hands a block to a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("block pushed into a full queue");

   // The engine never takes a block from an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("block popped from an empty queue");

   // Once the final digest word is taken, the output register is empty.
   a_digest_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("digest output still valid after its last word");

endmodule

>>> tb/sha256_digest_checker.sv
// Checker for the SHA-256 byte-stream hasher: predicts each digest word and compares it.
`timescale 1ns / 1ps

module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] digest_word
   input  logic [1:0]  rsp_tuser,   // [1:0] word_index
   input  logic        rsp_tlast,   // last_word
   output int          fail_count,
   output int          words_due
);

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   localparam int          LEN_OFFSET = 56;
   localparam int          WORDS_OUT  = 4;
   localparam logic [60:0] COUNT_MAX  = '1;

   typedef struct {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   digest_word_type digest_words_due [$];

   logic [31:0] chain_h [8];
   logic [7:0]  msg_block [64];
   int unsigned fill;
   logic [60:0] byte_count;

   initial begin
      fail_count = 0;
      words_due = 0;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_message();
      chain_h = SHA_IV;
      fill = 0;
      byte_count = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      v = chain_h;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain_h[i] = chain_h[i] + v[i];
   endfunction

   // Takes one accepted request; an end request queues the four digest words.
   function automatic void absorb_request(input logic [7:0] data, input logic valid,
                                          input logic eom);
      logic [63:0]     bit_len;
      digest_word_type dw;
      if (valid) begin
         msg_block[fill] = data;
         fill++;
         if (byte_count != COUNT_MAX)
            byte_count++;
         if (fill == 64) begin
            compress_block();
            fill = 0;
         end
      end
      if (eom) begin
         bit_len = {byte_count, 3'b000};
         msg_block[fill] = PAD_BYTE;
         fill++;
         // No room for the length field: pad out this block and start another.
         if (fill > LEN_OFFSET) begin
            for (int i = fill; i < 64; i++)
               msg_block[i] = 8'h00;
            compress_block();
            fill = 0;
         end
         for (int i = fill; i < LEN_OFFSET; i++)
            msg_block[i] = 8'h00;
         for (int i = 0; i < 8; i++)
            msg_block[63-i] = bit_len[8*i +: 8];
         compress_block();
         for (int k = 0; k < WORDS_OUT; k++) begin
            dw.word = {chain_h[2*k], chain_h[2*k+1]};
            dw.index = 2'(k);
            dw.last = (k == WORDS_OUT - 1);
            digest_words_due = {digest_words_due, dw};
         end
         restart_message();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_digest_word();
      digest_word_type want;
      if (digest_words_due.size() == 0) begin
         report_mismatch("digest word with none pending", rsp_tdata, 64'h0);
      end else begin
         want = digest_words_due.pop_front();
         if (rsp_tdata !== want.word)
            report_mismatch("digest_word", rsp_tdata, want.word);
         if (rsp_tuser !== want.index)
            report_mismatch("word_index", 64'(rsp_tuser), 64'(want.index));
         if (rsp_tlast !== want.last)
            report_mismatch("last_word", 64'(rsp_tlast), 64'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
         digest_words_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_digest_word();
         if (req_tvalid && req_tready)
            absorb_request(req_tdata, req_tuser[0], req_tlast);
      end
      words_due = digest_words_due.size();
   end

endmodule

>>> tb/sha256_byte_stream_hasher_tb.sv
// Top of the SHA-256 byte-stream hasher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic [0:0]  req_tuser;   // [0] byte_valid
   logic        req_tlast;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] digest_word
   logic [1:0]  rsp_tuser;   // [1:0] word_index
   logic        rsp_tlast;   // last_word

   int fail_count;
   int words_due;

   // Idle odds in percent for the sender and the receiver; the stimulus
   // process moves them through the three idling phases.
   int unsigned tx_idle_pct;
   int unsigned rx_idle_pct;

   // Raised by the stimulus process to ask the receiver for one long hold-off.
   bit long_stall_armed;

   // Requests that carry a byte or end a message; pure noise is not counted.
   int items_sent;
   int messages_sent;

   sha256_byte_stream_hasher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sha256_digest_checker digest_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A correct run ends well before this time-out even with the
   // heaviest idling, so the margin is wide.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: ready changes at the falling edge. A long hold-off, when armed,
   // is counted here cycle by cycle; otherwise ready follows the idle odds.
   initial begin
      int stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (long_stall_armed) begin
            long_stall_armed = 1'b0;
            stall_left = 600;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offers one request. It is entered at a falling edge and returns at the
   // falling edge after the request was accepted, with valid still high so
   // that back-to-back requests leave no gap.
   task automatic send_item(input logic [7:0] data, input logic valid, input logic eom);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= valid;
      req_tlast <= eom;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (valid || eom)
         items_sent++;
      @(negedge clock);
   endtask

   // One message of random bytes. The end flag either rides on the last byte
   // or comes on a separate request without a byte; the empty message always
   // ends with such a request. Invalid bytes are sprinkled in as noise.
   task automatic send_message(input int len, input bit eom_on_byte, input int noise_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == len - 1) && eom_on_byte);
      end
      if (len == 0 || !eom_on_byte)
         send_item(8'($urandom), 1'b0, 1'b1);
      messages_sent++;
   endtask

   // Mostly short messages, with a good share placed at the padding and
   // block boundaries and a few that span two or three blocks.
   function automatic int pick_length();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5)
         return $urandom_range(24);
      if (sel < 8) begin
         case ($urandom_range(3))
            0: return 55;
            1: return 56;
            2: return 63;
            default: return 64;
         endcase
      end
      return $urandom_range(130, 65);
   endfunction

   // Stops offering and waits until every digest word has been delivered.
   task automatic drain_digests();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (words_due != 0);
   endtask

   initial begin
      bit pressure_done;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      reset = 1'b1;
      tx_idle_pct = 33;
      rx_idle_pct = 81;
      long_stall_armed = 1'b0;
      items_sent = 0;
      messages_sent = 0;
      pressure_done = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The empty message: an end request with no byte.
      send_item(8'h00, 1'b0, 1'b1);
      // A single 0xff byte carried on the end request itself.
      send_item(8'hff, 1'b1, 1'b1);
      // Invalid bytes in the middle are skipped; the end request has no byte.
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h33, 1'b0, 1'b1);
      // The classic three-character message "abc".
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Alternating bit patterns, then an end request whose ignored byte is all ones.
      send_item(8'haa, 1'b1, 1'b0);
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      drain_digests();

      // Random part in three idling phases: a slow receiver, then a slow
      // sender, then no idling at all.
      while (items_sent < 430 || messages_sent < 14) begin
         if (items_sent < 143) begin
            tx_idle_pct = 33;
            rx_idle_pct = 81;
         end else if (items_sent < 286) begin
            tx_idle_pct = 81;
            rx_idle_pct = 33;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (!pressure_done && items_sent >= 290) begin
            // Let everything settle, then hold the receiver off for a long
            // stretch. The first digest gets stuck at the output and the
            // second message's final block stalls the engine behind it, so
            // the blocks of the long third message fill the queue and the
            // input is back-pressured until the hold-off ends.
            drain_digests();
            long_stall_armed = 1'b1;
            send_message(5, 1'b1, 0);
            send_message(10, 1'b1, 0);
            send_message(130, 1'b0, 0);
            pressure_done = 1'b1;
         end else begin
            send_message(pick_length(), 1'($urandom_range(1)), 5);
         end
      end

      // Wait for the last digest, then a little longer so that a stray extra
      // word would still be caught by the checker.
      drain_digests();
      repeat (200) @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
design/sha_pkg.sv
design/sha_front.sv
design/sha_queue.sv
design/sha_back.sv
design/sha256_byte_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/sha256_byte_stream_hasher_tb.sv
